[design/sau_pkg.sv]
// sau_pkg: shared types, constants and range helper for the signed arithmetic unit.
// No dependencies.
package sau_pkg;

    localparam int MAX_WIDTH = 32;
    localparam int DATA_W    = 32;
    localparam int WID_W     = 6;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int N_CELLS   = DATA_W;

    localparam logic [WID_W-1:0] WIDTH_MIN   = WID_W'(2);
    localparam logic [WID_W-1:0] WIDTH_MAX   = WID_W'((MAX_WIDTH < 32) ? MAX_WIDTH : 32);
    localparam logic [WID_W-1:0] WIDTH_RESET = WID_W'(8);

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } t_act;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OPND    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_DIVZERO = 2'd3
    } t_status;

    // One transaction as it travels down the divider cells.
    typedef struct packed {
        t_act                      act;
        t_status                   st;
        logic [WID_W-1:0]          w;
        logic                      neg;
        logic [DATA_W-1:0]         rem;
        logic [DATA_W-1:0]         dvd;
        logic [DATA_W-1:0]         dvs;
        logic [DATA_W-1:0]         quo;
        logic signed [PROD_W-1:0]  res;
    } t_tok;

    function automatic logic in_range(input logic signed [PROD_W-1:0] v,
                                      input logic [WID_W-1:0] w);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = (PROD_W'(1) <<< (w - WID_W'(1))) - PROD_W'(1);
        lo = -hi - PROD_W'(1);
        return (v >= lo) && (v <= hi);
    endfunction

endpackage

[design/sau_front.sv]
// sau_front: operand range check, add/sub/multiply and divider setup stage.
// Depends on sau_pkg.
module sau_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [1:0]                 i_action,
    input  logic signed [31:0]         i_operand_a,
    input  logic signed [31:0]         i_operand_b,
    input  logic [sau_pkg::WID_W-1:0]  i_width,
    output logic                       o_valid,
    output sau_pkg::t_tok              o_tok
);
    import sau_pkg::*;

    logic [WID_W-1:0]         eff_w;
    logic signed [PROD_W-1:0] a64;
    logic signed [PROD_W-1:0] b64;
    t_tok                     n_tok;
    t_tok                     r_tok;
    logic                     r_valid;

    always_comb begin
        if (i_width < WIDTH_MIN) begin
            eff_w = WIDTH_MIN;
        end else if (i_width > WIDTH_MAX) begin
            eff_w = WIDTH_MAX;
        end else begin
            eff_w = i_width;
        end
        a64 = PROD_W'(i_operand_a);
        b64 = PROD_W'(i_operand_b);

        n_tok     = '0;
        n_tok.act = t_act'(i_action);
        n_tok.w   = eff_w;
        n_tok.neg = i_operand_a[DATA_W-1] ^ i_operand_b[DATA_W-1];
        n_tok.dvd = i_operand_a[DATA_W-1] ? DATA_W'(-i_operand_a) : DATA_W'(i_operand_a);
        n_tok.dvs = i_operand_b[DATA_W-1] ? DATA_W'(-i_operand_b) : DATA_W'(i_operand_b);

        if (!in_range(a64, eff_w) || !in_range(b64, eff_w)) begin
            n_tok.st = ST_OPND;
        end else if (n_tok.act == ACT_DIV && i_operand_b == '0) begin
            n_tok.st = ST_DIVZERO;
        end else begin
            n_tok.st = ST_OK;
        end

        unique case (n_tok.act)
            ACT_ADD: n_tok.res = a64 + b64;
            ACT_SUB: n_tok.res = a64 - b64;
            ACT_MUL: n_tok.res = i_operand_a * i_operand_b;
            default: n_tok.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_tok <= n_tok;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;
endmodule

[design/sau_cell.sv]
// sau_cell: one restoring-division step, one quotient bit per cell.
// Depends on sau_pkg.
module sau_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  sau_pkg::t_tok  i_tok,
    output logic           o_valid,
    output sau_pkg::t_tok  o_tok
);
    import sau_pkg::*;

    logic [DATA_W:0] trial;
    logic            fits;
    t_tok            n_tok;
    t_tok            r_tok;
    logic            r_valid;

    always_comb begin
        trial     = {i_tok.rem, i_tok.dvd[DATA_W-1]};
        fits      = trial >= {1'b0, i_tok.dvs};
        n_tok     = i_tok;
        n_tok.dvd = {i_tok.dvd[DATA_W-2:0], 1'b0};
        n_tok.rem = fits ? DATA_W'(trial - {1'b0, i_tok.dvs}) : trial[DATA_W-1:0];
        n_tok.quo = {i_tok.quo[DATA_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_tok <= n_tok;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;
endmodule

[design/sau_back.sv]
// sau_back: quotient sign fix, result range check and output register.
// Depends on sau_pkg.
module sau_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  sau_pkg::t_tok        i_tok,
    output logic                 o_valid,
    output logic signed [31:0]   o_result_value,
    output logic [1:0]           o_status_code
);
    import sau_pkg::*;

    logic signed [PROD_W-1:0] quo64;
    logic signed [PROD_W-1:0] r64;
    t_status                  st;
    logic                     r_valid;
    logic [DATA_W-1:0]        r_value;
    t_status                  r_st;

    always_comb begin
        quo64 = PROD_W'({{DATA_W{1'b0}}, i_tok.quo});
        if (i_tok.act == ACT_DIV) begin
            r64 = i_tok.neg ? -quo64 : quo64;
        end else begin
            r64 = i_tok.res;
        end
        st = i_tok.st;
        if (st == ST_OK && !in_range(r64, i_tok.w)) begin
            st = ST_RANGE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_value <= (st == ST_OK) ? r64[DATA_W-1:0] : '0;
            r_st    <= st;
        end
    end

    assign o_valid        = r_valid;
    assign o_result_value = r_value;
    assign o_status_code  = r_st;
endmodule

[design/signed_arith_unit.sv]
// signed_arith_unit: top level, front stage, row of divider cells, back stage.
// Depends on sau_pkg, sau_front, sau_cell, sau_back.
//
// Usage:
//   Input channel i_valid/o_ready carries i_action, i_operand_a, i_operand_b.
//   Output channel o_valid/i_ready carries o_result_value, o_status_code.
//   A transaction moves when valid and ready are both high at a clock edge.
//   i_cfg_we/i_cfg_data write the word width (reset 8); write only when idle.
//   Every operation passes through one setup stage, 32 division cells
//   (one quotient bit each) and the output register. Add, subtract and
//   multiply ride the same row so results leave in order.
//   Throughput is one transaction per cycle while the output is not stalled.
//   The whole row shares one advance enable: when o_valid is high and
//   i_ready is low, every stage holds and o_ready drops until the output
//   is taken.
//   Synchronous reset (i_rst_n low) empties the row and restores width 8.
module signed_arith_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_action,
    input  logic signed [31:0]         i_operand_a,
    input  logic signed [31:0]         i_operand_b,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [31:0]         o_result_value,
    output logic [1:0]                 o_status_code,
    input  logic                       i_cfg_we,
    input  logic [sau_pkg::WID_W-1:0]  i_cfg_data
);
    import sau_pkg::*;

    logic [WID_W-1:0] r_width;
    logic             en;
    logic             v_chain [N_CELLS+1];
    t_tok             t_chain [N_CELLS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_width <= i_cfg_data;
        end
    end

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    sau_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_valid),
        .i_action    (i_action),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_width     (r_width),
        .o_valid     (v_chain[0]),
        .o_tok       (t_chain[0])
    );

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        sau_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v_chain[g]),
            .i_tok   (t_chain[g]),
            .o_valid (v_chain[g+1]),
            .o_tok   (t_chain[g+1])
        );
    end

    sau_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (v_chain[N_CELLS]),
        .i_tok          (t_chain[N_CELLS]),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_status_code  (o_status_code)
    );

    // error results carry zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status_code != ST_OK) |-> (o_result_value == '0))
        else $error("nonzero value with error status");

    // row is empty right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

    // a stalled output freezes the whole row, including the input side
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("input accepted while output stalled");

endmodule
